// ----- rtl/swd_pkg.sv -----
// shared constants and types for the serial wire debug bit sequencer
`default_nettype none

package swd_pkg;

  localparam int MAX_BITS     = 32;
  localparam int RESET_CLOCKS = 50;

  localparam int OP_W    = 3;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 6;
  localparam int LINE_W  = 33;

  localparam logic [OP_W-1:0] OP_LINE_RESET = 3'd0;
  localparam logic [OP_W-1:0] OP_WRITE      = 3'd1;
  localparam logic [OP_W-1:0] OP_WRITE_PAR  = 3'd2;
  localparam logic [OP_W-1:0] OP_READ       = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_PAR   = 3'd4;

  typedef struct packed {
    logic load;
    logic step;
  } swd_shift_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/swd_shift_unit.sv -----
// shared bit shifter: serializes write bits, assembles read bits, tracks parity
`default_nettype none

module swd_shift_unit
  import swd_pkg::*;
(
  input  wire logic                  clk,
  input  wire swd_shift_ctl_t        ctl,
  input  wire logic [LINE_W-1:0]     load_data,
  output logic                       cur_bit,
  output logic                       par_cur,
  output logic                       par_nxt,
  output logic [DATA_W-1:0]          word_cur,
  output logic [DATA_W-1:0]          word_nxt
);

  logic [LINE_W-1:0] data_r;
  logic [DATA_W-1:0] pos_r;
  logic [DATA_W-1:0] word_r;
  logic              par_r;

  assign cur_bit  = data_r[0];
  assign par_cur  = par_r;
  assign par_nxt  = par_r ^ data_r[0];
  assign word_cur = word_r;
  assign word_nxt = word_r | (pos_r & {DATA_W{data_r[0]}});

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data_r <= load_data;
      pos_r  <= {{(DATA_W-1){1'b0}}, 1'b1};
      word_r <= '0;
      par_r  <= 1'b0;
    end else if (ctl.step) begin
      data_r <= {1'b0, data_r[LINE_W-1:1]};
      pos_r  <= {pos_r[DATA_W-2:0], 1'b0};
      word_r <= word_nxt;
      par_r  <= par_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/swd_bit_sequencer.sv -----
// serial wire debug bit sequencer top level
//
// one command word enters on the in_ channel and produces one out_ word per
// SWCLK pulse, the final one marked by out_last. a command that makes no
// pulse (zero-bit write or read without parity and with no turnaround, or an
// undefined operation) gives a single word with every field zero except out_last.
// the sequencer emits at most one word per cycle into an output register;
// after a command is accepted the state register is loaded, and then its
// first word is registered into the output register. the shared shift unit
// serializes one bit per cycle while the output register is not held by
// out_stall. in_stall is high while a command is in progress and drops
// after its last word is loaded, so the next command can be taken while
// that word still waits in the output register. when out_stall is high and
// the output register holds a word, that word is kept and the sequencer
// waits. reset clears the sequencer, empties the output register and sets
// the line direction to host driving.
`default_nettype none

module swd_bit_sequencer
  import swd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [DATA_W-1:0] in_write_data,
  input  wire logic [CNT_W-1:0]  in_bit_count,
  input  wire logic [LINE_W-1:0] in_line_bits,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_clock_pulse,
  output logic                   out_drive_enable,
  output logic                   out_drive_value,
  output logic                   out_turnaround_flag,
  output logic [DATA_W-1:0]      out_read_word,
  output logic                   out_parity_bad,
  output logic                   out_last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_TURN = 3'd1;
  localparam logic [2:0] ST_DATA = 3'd2;
  localparam logic [2:0] ST_PAR  = 3'd3;
  localparam logic [2:0] ST_NONE = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic             reading_r, reading_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OP_W-1:0]  op_r;
  logic [CNT_W-1:0] left_r, left_nxt;
  logic             par_en_r;

  logic             accept, emit;
  logic             op_ok, is_rst, is_wr, is_rd, has_par, need_turn;
  logic [CNT_W-1:0] cnt_sat, n_data;
  logic             cur_rd;

  logic             e_clk, e_den, e_dval, e_turn, e_pbad, e_last;
  logic [DATA_W-1:0] e_word;

  logic                 out_clock_pulse_r, out_drive_enable_r, out_drive_value_r;
  logic                 out_turnaround_flag_r, out_parity_bad_r, out_last_r;
  logic [DATA_W-1:0]    out_read_word_r;

  swd_shift_ctl_t    sh_ctl;
  logic [LINE_W-1:0] sh_load_data;
  logic              sh_bit, sh_par_cur, sh_par_nxt;
  logic [DATA_W-1:0] sh_word_cur, sh_word_nxt;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign emit     = (state_r != ST_IDLE) && (!out_valid_r || !out_stall);

  // command decode
  always_comb begin
    is_rst  = (in_operation == OP_LINE_RESET);
    is_wr   = (in_operation == OP_WRITE) || (in_operation == OP_WRITE_PAR);
    is_rd   = (in_operation == OP_READ) || (in_operation == OP_READ_PAR);
    op_ok   = is_rst || is_wr || is_rd;
    has_par = (in_operation == OP_WRITE_PAR) || (in_operation == OP_READ_PAR);
    cnt_sat = (in_bit_count > CNT_W'(MAX_BITS)) ? CNT_W'(MAX_BITS) : in_bit_count;
    if (is_rst) begin
      n_data = CNT_W'(RESET_CLOCKS);
    end else if (op_ok) begin
      n_data = cnt_sat;
    end else begin
      n_data = '0;
    end
    need_turn    = op_ok && (reading_r != is_rd);
    sh_load_data = is_rd ? in_line_bits : {1'b0, in_write_data};
  end

  assign cur_rd = (op_r == OP_READ) || (op_r == OP_READ_PAR);

  swd_shift_unit u_shift (
    .clk       (clk),
    .ctl       (sh_ctl),
    .load_data (sh_load_data),
    .cur_bit   (sh_bit),
    .par_cur   (sh_par_cur),
    .par_nxt   (sh_par_nxt),
    .word_cur  (sh_word_cur),
    .word_nxt  (sh_word_nxt)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    left_nxt    = left_r;
    reading_nxt = reading_r;
    sh_ctl.load = accept;
    sh_ctl.step = 1'b0;
    e_clk  = 1'b0;
    e_den  = 1'b0;
    e_dval = 1'b0;
    e_turn = 1'b0;
    e_pbad = 1'b0;
    e_last = 1'b0;
    e_word = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          left_nxt = n_data;
          if (op_ok) begin
            reading_nxt = is_rd;
          end
          if (need_turn) begin
            state_nxt = ST_TURN;
          end else if (n_data != '0) begin
            state_nxt = ST_DATA;
          end else if (has_par) begin
            state_nxt = ST_PAR;
          end else begin
            state_nxt = ST_NONE;
          end
        end
      end
      ST_TURN: begin
        e_clk  = 1'b1;
        e_turn = 1'b1;
        e_last = (left_r == '0) && !par_en_r;
        if (emit) begin
          if (left_r != '0) begin
            state_nxt = ST_DATA;
          end else if (par_en_r) begin
            state_nxt = ST_PAR;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        e_clk  = 1'b1;
        e_last = (left_r == CNT_W'(1)) && !par_en_r;
        if (op_r == OP_LINE_RESET) begin
          e_den  = 1'b1;
          e_dval = 1'b1;
        end else if (!cur_rd) begin
          e_den  = 1'b1;
          e_dval = sh_bit;
        end else if (e_last) begin
          e_word = sh_word_nxt;
        end
        if (emit) begin
          sh_ctl.step = (op_r != OP_LINE_RESET);
          left_nxt    = left_r - CNT_W'(1);
          if (left_r == CNT_W'(1)) begin
            state_nxt = par_en_r ? ST_PAR : ST_IDLE;
          end
        end
      end
      ST_PAR: begin
        e_clk  = 1'b1;
        e_last = 1'b1;
        if (cur_rd) begin
          e_word = sh_word_cur;
          e_pbad = sh_par_nxt;
        end else begin
          e_den  = 1'b1;
          e_dval = sh_par_cur;
        end
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NONE: begin
        e_last = 1'b1;
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_stall) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      reading_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      reading_r   <= reading_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r <= left_nxt;
    if (accept) begin
      op_r     <= in_operation;
      par_en_r <= has_par;
    end
    if (emit) begin
      out_clock_pulse_r     <= e_clk;
      out_drive_enable_r    <= e_den;
      out_drive_value_r     <= e_dval;
      out_turnaround_flag_r <= e_turn;
      out_read_word_r       <= e_word;
      out_parity_bad_r      <= e_pbad;
      out_last_r            <= e_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_clock_pulse     = out_clock_pulse_r;
  assign out_drive_enable    = out_drive_enable_r;
  assign out_drive_value     = out_drive_value_r;
  assign out_turnaround_flag = out_turnaround_flag_r;
  assign out_read_word       = out_read_word_r;
  assign out_parity_bad      = out_parity_bad_r;
  assign out_last            = out_last_r;

endmodule

`default_nettype wire

// ----- verif/swd_bit_sequencer_tb.sv -----
// self-checking testbench for the serial wire debug bit sequencer with a built-in pulse predictor
`timescale 1ns / 1ps

module swd_bit_sequencer_tb;
  import swd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED_A = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_B = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_C = 3'd7;
  localparam int IDLE_LIMIT   = 2000;
  localparam int RANDOM_ITEMS = 258;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] wdata;
    logic [CNT_W-1:0]  cnt;
    logic [LINE_W-1:0] lines;
  } swd_cmd_t;

  typedef struct packed {
    logic              clock_pulse;
    logic              drive_enable;
    logic              drive_value;
    logic              turnaround_flag;
    logic [DATA_W-1:0] read_word;
    logic              parity_bad;
    logic              last;
  } swd_pulse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic out_stall = 1'b0;
  swd_cmd_t cur_cmd = '0;
  logic in_stall;
  logic out_valid;
  logic out_clock_pulse;
  logic out_drive_enable;
  logic out_drive_value;
  logic out_turnaround_flag;
  logic [DATA_W-1:0] out_read_word;
  logic out_parity_bad;
  logic out_last;

  swd_cmd_t cmd_q[$];
  swd_pulse_t pulse_q[$];
  logic target_driving = 1'b0;
  int total_items = 0;
  int accepted_cnt = 0;
  int fail_cnt = 0;
  int idle_cycles = 0;
  int in_gap = 0;
  int in_quiet = 0;
  int out_quiet = 0;
  int stall_left = 0;
  logic in_fire = 1'b0;
  logic fired;
  swd_pulse_t got_w;
  swd_pulse_t want_w;

  swd_bit_sequencer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_operation        (cur_cmd.op),
    .in_write_data       (cur_cmd.wdata),
    .in_bit_count        (cur_cmd.cnt),
    .in_line_bits        (cur_cmd.lines),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_clock_pulse     (out_clock_pulse),
    .out_drive_enable    (out_drive_enable),
    .out_drive_value     (out_drive_value),
    .out_turnaround_flag (out_turnaround_flag),
    .out_read_word       (out_read_word),
    .out_parity_bad      (out_parity_bad),
    .out_last            (out_last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic swd_pulse_t swclk_pulse(input logic den, input logic dval,
                                             input logic turn);
    swd_pulse_t p;
    p = '0;
    p.clock_pulse = 1'b1;
    p.drive_enable = den;
    p.drive_value = dval;
    p.turnaround_flag = turn;
    return p;
  endfunction

  task automatic predict_pulses(input swd_cmd_t c);
    swd_pulse_t seq [RESET_CLOCKS+1];
    int k;
    int n;
    int i;
    logic par;
    logic known;
    logic want_read;
    logic [DATA_W-1:0] word;
    k = 0;
    par = 1'b0;
    word = '0;
    known = 1'b1;
    want_read = 1'b0;
    n = (int'(c.cnt) > MAX_BITS) ? MAX_BITS : int'(c.cnt);
    case (c.op)
      OP_LINE_RESET, OP_WRITE, OP_WRITE_PAR: want_read = 1'b0;
      OP_READ, OP_READ_PAR: want_read = 1'b1;
      default: known = 1'b0;
    endcase
    if (known && want_read != target_driving) begin
      target_driving = want_read;
      seq[k] = swclk_pulse(1'b0, 1'b0, 1'b1);
      k++;
    end
    case (c.op)
      OP_LINE_RESET: begin
        for (i = 0; i < RESET_CLOCKS; i++) begin
          seq[k] = swclk_pulse(1'b1, 1'b1, 1'b0);
          k++;
        end
      end
      OP_WRITE, OP_WRITE_PAR: begin
        for (i = 0; i < n; i++) begin
          par ^= c.wdata[i];
          seq[k] = swclk_pulse(1'b1, c.wdata[i], 1'b0);
          k++;
        end
        if (c.op == OP_WRITE_PAR) begin
          seq[k] = swclk_pulse(1'b1, par, 1'b0);
          k++;
        end
        par = 1'b0;
      end
      OP_READ, OP_READ_PAR: begin
        for (i = 0; i < n; i++) begin
          word[i] = c.lines[i];
          par ^= c.lines[i];
          seq[k] = swclk_pulse(1'b0, 1'b0, 1'b0);
          k++;
        end
        if (c.op == OP_READ_PAR) begin
          par ^= c.lines[n];
          seq[k] = swclk_pulse(1'b0, 1'b0, 1'b0);
          k++;
        end else begin
          par = 1'b0;
        end
      end
      default: ;
    endcase
    if (k == 0) begin
      seq[0] = '0;
      seq[0].last = 1'b1;
      k = 1;
    end else begin
      seq[k-1].read_word = word;
      seq[k-1].parity_bad = par;
      seq[k-1].last = 1'b1;
    end
    for (i = 0; i < k; i++) pulse_q.push_back(seq[i]);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int next_in_gap();
    if (in_quiet > 0) begin
      in_quiet--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      in_quiet = $urandom_range(10, 40);
      return 0;
    end
    if ($urandom_range(0, 99) < 50) return 0;
    return gap_len();
  endfunction

  function automatic void add_cmd(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] wdata,
                                  input logic [CNT_W-1:0] cnt, input logic [LINE_W-1:0] lines);
    swd_cmd_t c;
    c.op = op;
    c.wdata = wdata;
    c.cnt = cnt;
    c.lines = lines;
    cmd_q.push_back(c);
  endfunction

  function automatic logic [LINE_W-1:0] rand_lines();
    return LINE_W'({$urandom, $urandom});
  endfunction

  function automatic logic [CNT_W-1:0] rand_cnt();
    if ($urandom_range(0, 99) < 85) return CNT_W'($urandom_range(0, 32));
    return CNT_W'($urandom_range(33, 63));
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      fired = in_fire;
      in_fire = 1'b0;
      if (fired) in_gap = next_in_gap();
      if (!in_valid || fired) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd <= cmd_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side stall
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (out_quiet > 0) begin
      out_quiet--;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < 2) out_quiet = $urandom_range(40, 150);
      else if ($urandom_range(0, 99) < 25) stall_left = gap_len();
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_pulses(cur_cmd);
        accepted_cnt++;
        in_fire = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got_w = {out_clock_pulse, out_drive_enable, out_drive_value, out_turnaround_flag,
                 out_read_word, out_parity_bad, out_last};
        if (pulse_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected word: got %h", got_w);
        end else begin
          want_w = pulse_q.pop_front();
          if (got_w !== want_w) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: got %h expected %h", got_w, want_w);
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    int rnd_cnt;
    int r;
    // directed words
    add_cmd(OP_WRITE, '0, 6'd0, '0);
    add_cmd(OP_LINE_RESET, '1, 6'd0, '0);
    add_cmd(OP_WRITE, 32'hFFFFFFFF, 6'd32, '0);
    add_cmd(OP_WRITE_PAR, 32'h0000E79E, 6'd16, '0);
    add_cmd(OP_WRITE_PAR, '0, 6'd0, '1);
    add_cmd(OP_WRITE, 32'h5A5A5A5A, 6'd63, '0);
    add_cmd(OP_UNUSED_A, '1, 6'd32, '1);
    add_cmd(OP_READ, '0, 6'd0, '1);
    add_cmd(OP_READ_PAR, '0, 6'd0, '1);
    add_cmd(OP_READ, '1, 6'd32, '1);
    add_cmd(OP_READ_PAR, '0, 6'd32, 33'h100000000);
    add_cmd(OP_READ_PAR, '0, 6'd32, 33'h000000001);
    add_cmd(OP_READ, '0, 6'd40, 33'h0AAAA5555);
    add_cmd(OP_UNUSED_B, '0, 6'd5, '0);
    add_cmd(OP_UNUSED_C, '1, 6'd63, '1);
    add_cmd(OP_WRITE, '0, 6'd0, '0);
    add_cmd(OP_READ, '0, 6'd0, '0);
    add_cmd(OP_LINE_RESET, '0, 6'd63, '1);
    add_cmd(OP_WRITE_PAR, 32'hFFFFFFFF, 6'd32, '0);
    add_cmd(OP_READ_PAR, '0, 6'd63, '1);
    add_cmd(OP_WRITE, 32'h80000001, 6'd1, '0);
    add_cmd(OP_UNUSED_A, '0, 6'd0, '0);

    // random words, mostly well-formed request / ack / data transfers
    rnd_cnt = 0;
    while (rnd_cnt < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        add_cmd(OP_WRITE, $urandom, 6'd8, rand_lines());
        add_cmd(OP_READ, $urandom, 6'd3, rand_lines());
        if ($urandom_range(0, 1) == 1) add_cmd(OP_READ_PAR, $urandom, 6'd32, rand_lines());
        else add_cmd(OP_WRITE_PAR, $urandom, 6'd32, rand_lines());
        rnd_cnt += 3;
      end else if (r < 70) begin
        add_cmd(OP_LINE_RESET, $urandom, rand_cnt(), rand_lines());
        rnd_cnt++;
      end else if (r < 75) begin
        add_cmd(OP_W'($urandom_range(5, 7)), $urandom, rand_cnt(), rand_lines());
        rnd_cnt++;
      end else begin
        add_cmd(OP_W'($urandom_range(1, 4)), $urandom, rand_cnt(), rand_lines());
        rnd_cnt++;
      end
    end
    total_items = cmd_q.size();

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (accepted_cnt < total_items || pulse_q.size() != 0);
    repeat (60) @(negedge clk);

    if (fail_cnt == 0 && pulse_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
